// ===== rtl/core/dtmf_tg_pkg.sv =====
package dtmf_tg_pkg;

    // Default build parameters of the generator.
    localparam int PHASE_BITS_DEFAULT      = 32;
    localparam int TABLE_ADDR_BITS_DEFAULT = 10;
    localparam int SAMPLE_BITS_DEFAULT     = 16;

    // Fixed widths of the channel fields.
    localparam int KEY_W    = 8;
    localparam int OUT_W    = 16;
    localparam int LENGTH_W = 16;

    localparam logic [LENGTH_W-1:0] TONE_LENGTH_RESET = 16'd4000;

    localparam int OUT_MAX = 32767;

    localparam logic [63:0] RATE_HZ    = 64'd8000;
    localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

    localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

    // Keypad characters.
    localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
    localparam logic [KEY_W-1:0] KEY_1    = 8'h31;
    localparam logic [KEY_W-1:0] KEY_2    = 8'h32;
    localparam logic [KEY_W-1:0] KEY_3    = 8'h33;
    localparam logic [KEY_W-1:0] KEY_4    = 8'h34;
    localparam logic [KEY_W-1:0] KEY_5    = 8'h35;
    localparam logic [KEY_W-1:0] KEY_6    = 8'h36;
    localparam logic [KEY_W-1:0] KEY_7    = 8'h37;
    localparam logic [KEY_W-1:0] KEY_8    = 8'h38;
    localparam logic [KEY_W-1:0] KEY_9    = 8'h39;
    localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
    localparam logic [KEY_W-1:0] KEY_B    = 8'h42;
    localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
    localparam logic [KEY_W-1:0] KEY_D    = 8'h44;
    localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;

    typedef struct packed {
        logic             start_tone;
        logic [KEY_W-1:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample_value;
        logic                    tone_active;
        logic                    last_sample;
    } out_item_t;

    typedef struct packed {
        logic tone_active;
        logic last_sample;
    } tone_flags_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] column;
    } key_cell_t;

    function automatic key_cell_t decode_key(logic [KEY_W-1:0] key);
        key_cell_t key_pos;
        key_pos.valid = 1'b1;
        unique case (key)
            KEY_1:    {key_pos.row, key_pos.column} = {2'd0, 2'd0};
            KEY_2:    {key_pos.row, key_pos.column} = {2'd0, 2'd1};
            KEY_3:    {key_pos.row, key_pos.column} = {2'd0, 2'd2};
            KEY_A:    {key_pos.row, key_pos.column} = {2'd0, 2'd3};
            KEY_4:    {key_pos.row, key_pos.column} = {2'd1, 2'd0};
            KEY_5:    {key_pos.row, key_pos.column} = {2'd1, 2'd1};
            KEY_6:    {key_pos.row, key_pos.column} = {2'd1, 2'd2};
            KEY_B:    {key_pos.row, key_pos.column} = {2'd1, 2'd3};
            KEY_7:    {key_pos.row, key_pos.column} = {2'd2, 2'd0};
            KEY_8:    {key_pos.row, key_pos.column} = {2'd2, 2'd1};
            KEY_9:    {key_pos.row, key_pos.column} = {2'd2, 2'd2};
            KEY_C:    {key_pos.row, key_pos.column} = {2'd2, 2'd3};
            KEY_STAR: {key_pos.row, key_pos.column} = {2'd3, 2'd0};
            KEY_0:    {key_pos.row, key_pos.column} = {2'd3, 2'd1};
            KEY_HASH: {key_pos.row, key_pos.column} = {2'd3, 2'd2};
            KEY_D:    {key_pos.row, key_pos.column} = {2'd3, 2'd3};
            default: begin
                key_pos.valid  = 1'b0;
                key_pos.row    = 2'd0;
                key_pos.column = 2'd0;
            end
        endcase
        return key_pos;
    endfunction

    // Phase step per sample, rounded to nearest with halves upwards.
    function automatic logic [63:0] phase_inc(int unsigned hz, int phase_bits);
        logic [63:0] scaled;
        scaled = 64'(hz) << phase_bits;
        return (scaled + RATE_HZ / 64'd2) / RATE_HZ;
    endfunction

    // The functions below only run at elaboration to fill the sine table.

    // floor(a * b / 2^60)
    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Long division, one quotient bit per step.
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine (odd series) or cosine (even series) of x in Q60 by Taylor series.
    function automatic logic [63:0] taylor_q60(logic [63:0] x, logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic        minus;
        x2    = mul_q60(x, x);
        term  = odd ? x : ONE_Q60;
        sum   = term;
        n     = odd ? 64'd1 : 64'd0;
        minus = 1'b1;
        for (int i = 0; i < 31; i++) begin
            if (term != 64'd0 && n < 64'd60) begin
                term  = div_u64(mul_q60(term, x2), (n + 64'd1) * (n + 64'd2));
                n     = n + 64'd2;
                sum   = minus ? sum - term : sum + term;
                minus = !minus;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] angle_q60(logic [63:0] m, int addr_bits);
        logic [63:0] low;
        low = TWO_PI_Q60 & ((64'd1 << addr_bits) - 64'd1);
        return (TWO_PI_Q60 >> addr_bits) * m + ((low * m) >> addr_bits);
    endfunction

    function automatic logic [63:0] quarter_sine(logic [63:0] m, int addr_bits);
        logic [63:0] quarter;
        quarter = 64'd1 << (addr_bits - 2);
        if (m <= (64'd1 << (addr_bits - 3))) begin
            return taylor_q60(angle_q60(m, addr_bits), 1'b1);
        end
        return taylor_q60(angle_q60(quarter - m, addr_bits), 1'b0);
    endfunction

    // Entry k of the sine table, rounded with halves away from zero.
    function automatic logic [31:0] sine_entry(logic [63:0] k, int addr_bits,
                                               int sample_bits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] amp;
        logic [63:0] v;
        logic [63:0] y;
        logic [63:0] mag;
        quarter = 64'd1 << (addr_bits - 2);
        q       = k >> (addr_bits - 2);
        r       = k & (quarter - 64'd1);
        amp     = (64'd1 << (sample_bits - 1)) - 64'd1;
        v       = quarter_sine(q[0] ? quarter - r : r, addr_bits);
        y       = (v & 64'h3FFF_FFFF) * amp + (64'd1 << 59);
        mag     = ((v >> 30) * amp + (y >> 30)) >> 30;
        return (q >= 64'd2) ? -mag[31:0] : mag[31:0];
    endfunction

endpackage

// ===== rtl/core/dtmf_tg_ctrl.sv =====
module dtmf_tg_ctrl #(
    parameter int PHASE_BITS      = dtmf_tg_pkg::PHASE_BITS_DEFAULT,
    parameter int TABLE_ADDR_BITS = dtmf_tg_pkg::TABLE_ADDR_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_accept,
    input  dtmf_tg_pkg::in_item_t               item,
    input  logic [dtmf_tg_pkg::LENGTH_W-1:0]    tone_length,
    output logic [TABLE_ADDR_BITS-1:0]          row_addr,
    output logic [TABLE_ADDR_BITS-1:0]          column_addr,
    output dtmf_tg_pkg::tone_flags_t            flags
);

    localparam logic [3:0][PHASE_BITS-1:0] ROW_INC = {
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::ROW_HZ[3], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::ROW_HZ[2], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::ROW_HZ[1], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::ROW_HZ[0], PHASE_BITS))
    };
    localparam logic [3:0][PHASE_BITS-1:0] COL_INC = {
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::COL_HZ[3], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::COL_HZ[2], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::COL_HZ[1], PHASE_BITS)),
        PHASE_BITS'(dtmf_tg_pkg::phase_inc(dtmf_tg_pkg::COL_HZ[0], PHASE_BITS))
    };

    logic [PHASE_BITS-1:0]               row_phase_reg, row_phase_next;
    logic [PHASE_BITS-1:0]               column_phase_reg, column_phase_next;
    logic [1:0]                          row_select_reg, row_select_next;
    logic [1:0]                          column_select_reg, column_select_next;
    logic [dtmf_tg_pkg::LENGTH_W-1:0]    samples_done_reg, samples_done_next;
    logic                                playing_reg, playing_next;

    dtmf_tg_pkg::key_cell_t              key_pos;
    logic                                new_tone;
    logic                                play_now;
    logic [PHASE_BITS-1:0]               row_phase_now;
    logic [PHASE_BITS-1:0]               column_phase_now;
    logic [dtmf_tg_pkg::LENGTH_W-1:0]    count_now;
    logic [dtmf_tg_pkg::LENGTH_W-1:0]    count_inc;
    logic [dtmf_tg_pkg::LENGTH_W-1:0]    length_eff;
    logic                                last_now;

    always_comb begin
        key_pos    = dtmf_tg_pkg::decode_key(item.key_code);
        new_tone   = item.start_tone && key_pos.valid;
        play_now   = new_tone || (playing_reg && !item.start_tone);

        row_phase_now    = new_tone ? '0 : row_phase_reg;
        column_phase_now = new_tone ? '0 : column_phase_reg;
        count_now        = new_tone ? '0 : samples_done_reg;
        row_select_next    = new_tone ? key_pos.row : row_select_reg;
        column_select_next = new_tone ? key_pos.column : column_select_reg;

        // A length of zero behaves as a single sample.
        length_eff = (tone_length == '0) ? dtmf_tg_pkg::LENGTH_W'(1) : tone_length;
        count_inc  = count_now + dtmf_tg_pkg::LENGTH_W'(1);
        last_now   = count_inc >= length_eff;

        if (play_now) begin
            row_phase_next    = row_phase_now + ROW_INC[row_select_next];
            column_phase_next = column_phase_now + COL_INC[column_select_next];
            samples_done_next = count_inc;
            playing_next      = !last_now;
        end else begin
            row_phase_next    = row_phase_reg;
            column_phase_next = column_phase_reg;
            samples_done_next = samples_done_reg;
            playing_next      = 1'b0;
        end

        row_addr          = row_phase_now[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        column_addr       = column_phase_now[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        flags.tone_active = play_now;
        flags.last_sample = play_now && last_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_phase_reg     <= '0;
            column_phase_reg  <= '0;
            row_select_reg    <= '0;
            column_select_reg <= '0;
            samples_done_reg  <= '0;
            playing_reg       <= 1'b0;
        end else if (item_accept) begin
            row_phase_reg     <= row_phase_next;
            column_phase_reg  <= column_phase_next;
            row_select_reg    <= row_select_next;
            column_select_reg <= column_select_next;
            samples_done_reg  <= samples_done_next;
            playing_reg       <= playing_next;
        end
    end

endmodule

// ===== rtl/core/dtmf_tg_sine_rom.sv =====
module dtmf_tg_sine_rom #(
    parameter int TABLE_ADDR_BITS = dtmf_tg_pkg::TABLE_ADDR_BITS_DEFAULT,
    parameter int SAMPLE_BITS     = dtmf_tg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [TABLE_ADDR_BITS-1:0]     row_addr,
    input  logic [TABLE_ADDR_BITS-1:0]     column_addr,
    output logic signed [SAMPLE_BITS-1:0]  row_sine,
    output logic signed [SAMPLE_BITS-1:0]  column_sine
);

    localparam int ROM_SIZE = 1 << TABLE_ADDR_BITS;

    typedef logic [ROM_SIZE-1:0][SAMPLE_BITS-1:0] rom_image_t;

    function automatic rom_image_t build_image();
        rom_image_t  image;
        logic [31:0] entry;
        for (int k = 0; k < ROM_SIZE; k++) begin
            entry    = dtmf_tg_pkg::sine_entry(64'(k), TABLE_ADDR_BITS, SAMPLE_BITS);
            image[k] = entry[SAMPLE_BITS-1:0];
        end
        return image;
    endfunction

    localparam rom_image_t SINE_ROM = build_image();

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_sine    <= SINE_ROM[row_addr];
            column_sine <= SINE_ROM[column_addr];
        end
    end

endmodule

// ===== rtl/core/dtmf_tg_mix.sv =====
module dtmf_tg_mix #(
    parameter int SAMPLE_BITS = dtmf_tg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  row_sine,
    input  logic signed [SAMPLE_BITS-1:0]  column_sine,
    input  dtmf_tg_pkg::tone_flags_t       flags,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dtmf_tg_pkg::out_item_t         m_data
);

    localparam int WORK_W = 26;
    localparam int SHR    = (SAMPLE_BITS <= 16) ? 1 : SAMPLE_BITS - 15;
    localparam int SHL    = (SAMPLE_BITS <= 16) ? 16 - SAMPLE_BITS : 0;
    localparam logic signed [WORK_W-1:0] LIMIT = WORK_W'(dtmf_tg_pkg::OUT_MAX);

    logic                      m_valid_reg, m_valid_next;
    dtmf_tg_pkg::out_item_t    m_data_reg, m_data_next;
    logic signed [WORK_W-1:0]  sum;
    logic signed [WORK_W-1:0]  scaled;
    logic signed [WORK_W-1:0]  clamped;

    always_comb begin
        // Floor halving of the sum, then alignment to Q1.15.
        sum    = WORK_W'(row_sine) + WORK_W'(column_sine);
        scaled = (sum >>> SHR) <<< SHL;
        if (scaled > LIMIT) begin
            clamped = LIMIT;
        end else if (scaled < -LIMIT) begin
            clamped = -LIMIT;
        end else begin
            clamped = scaled;
        end

        in_ready     = !m_valid_reg || m_ready;
        m_valid_next = in_ready ? in_valid : m_valid_reg;

        m_data_next.tone_active  = flags.tone_active;
        m_data_next.last_sample  = flags.last_sample;
        m_data_next.sample_value = flags.tone_active ? clamped[dtmf_tg_pkg::OUT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/dtmf_tone_generator.sv =====
// DTMF tone generator.
//
// Each transfer on the s_ channel is one 8 kHz sample tick. A tick with
// start_tone set and a keypad character in key_code (0-9, A-D, * or #)
// starts that key's tone from phase zero; a start with any other code stops
// the tone and gives silence. Each tick yields exactly one transfer on the
// m_ channel: the average of the row and column sines in Q1.15, with
// tone_active set while a tone plays and last_sample on its final sample.
// Idle ticks give an all-zero result.
// The tone length in samples is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the generator is idle, which the block does
// not enforce. It resets to 4000 (half a second). One tick is accepted in
// every cycle while s_ready is high: the phase accumulators and sample
// counter update with each accepted tick, the sine table is a ROM with two
// registered read ports, and the scaled sum goes to the result register.
// When the receiver stalls, the table stage and the result register still
// hold one tick each, so s_ready drops only once both are full.
// A synchronous active-low reset clears the phases, the counter and both
// valid flags; the generator then sits idle and needs no warm-up.
module dtmf_tone_generator #(
    parameter int PHASE_BITS      = dtmf_tg_pkg::PHASE_BITS_DEFAULT,
    parameter int TABLE_ADDR_BITS = dtmf_tg_pkg::TABLE_ADDR_BITS_DEFAULT,
    parameter int SAMPLE_BITS     = dtmf_tg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dtmf_tg_pkg::in_item_t             s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dtmf_tg_pkg::out_item_t            m_data,
    input  logic                              cfg_wr_en,
    input  logic [dtmf_tg_pkg::LENGTH_W-1:0]  cfg_wr_data
);

    logic [dtmf_tg_pkg::LENGTH_W-1:0] tone_length_reg;

    logic                              s_accept;
    logic [TABLE_ADDR_BITS-1:0]        row_addr;
    logic [TABLE_ADDR_BITS-1:0]        column_addr;
    dtmf_tg_pkg::tone_flags_t          tick_flags;

    // Table stage: holds the tick whose sine readings are in the ROM outputs.
    logic                              rd_valid_reg, rd_valid_next;
    dtmf_tg_pkg::tone_flags_t          rd_flags_reg;
    logic signed [SAMPLE_BITS-1:0]     row_sine;
    logic signed [SAMPLE_BITS-1:0]     column_sine;
    logic                              mix_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_length_reg <= dtmf_tg_pkg::TONE_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            tone_length_reg <= cfg_wr_data;
        end
    end

    // The table stage takes a new tick when it is empty or its tick moves on.
    assign s_ready  = !rd_valid_reg || mix_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            rd_valid_next = 1'b1;
        end else if (mix_ready) begin
            rd_valid_next = 1'b0;
        end else begin
            rd_valid_next = rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_flags_reg <= tick_flags;
        end
    end

    dtmf_tg_ctrl #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (s_accept),
        .item        (s_data),
        .tone_length (tone_length_reg),
        .row_addr    (row_addr),
        .column_addr (column_addr),
        .flags       (tick_flags)
    );

    dtmf_tg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_sine_rom (
        .aclk        (aclk),
        .rd_en       (s_accept),
        .row_addr    (row_addr),
        .column_addr (column_addr),
        .row_sine    (row_sine),
        .column_sine (column_sine)
    );

    dtmf_tg_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rd_valid_reg),
        .in_ready    (mix_ready),
        .row_sine    (row_sine),
        .column_sine (column_sine),
        .flags       (rd_flags_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== tb/tb_dtmf_tone_generator.sv =====
module tb_dtmf_tone_generator;
    import dtmf_tg_pkg::*;

    // The checker is built for the default generator parameters, which are the
    // ones the instance below uses.
    localparam int PH_W     = PHASE_BITS_DEFAULT;
    localparam int ADDR_W   = TABLE_ADDR_BITS_DEFAULT;
    localparam int SAMP_W   = SAMPLE_BITS_DEFAULT;
    localparam int LUT_SIZE = 1 << ADDR_W;

    localparam real TWO_PI = 6.283185307179586;

    // Cycles without any transfer on either channel before the run is declared
    // hung. The longest legal quiet spell is a long source gap overlapping a
    // long sink stall, plus the short pause around a register write.
    localparam int QUIET_LIMIT = 1000;

    localparam int RANDOM_PHASES   = 15;
    localparam int ITEMS_PER_PHASE = 105;

    // Keypad characters in row-major order, so that the position of a key in
    // this list is row * 4 + column.
    localparam logic [KEY_W-1:0] KEYPAD [16] = '{
        KEY_1,    KEY_2, KEY_3,    KEY_A,
        KEY_4,    KEY_5, KEY_6,    KEY_B,
        KEY_7,    KEY_8, KEY_9,    KEY_C,
        KEY_STAR, KEY_0, KEY_HASH, KEY_D
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    in_item_t            s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    out_item_t           m_data;
    logic                cfg_wr_en   = 1'b0;
    logic [LENGTH_W-1:0] cfg_wr_data = '0;

    always #10 aclk = ~aclk;

    dtmf_tone_generator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Tone model. It mirrors the generator's state: the two phase
    // accumulators, the selected row and column, the count of samples played,
    // whether a tone is running, and the programmed tone length.
    // ------------------------------------------------------------------
    int                  sine_lut [LUT_SIZE];
    logic [PH_W-1:0]     row_step [4];
    logic [PH_W-1:0]     col_step [4];
    logic [PH_W-1:0]     row_acc    = '0;
    logic [PH_W-1:0]     col_acc    = '0;
    logic [1:0]          row_sel    = '0;
    logic [1:0]          col_sel    = '0;
    logic [15:0]         done_count = '0;
    logic                tone_on    = 1'b0;
    logic [LENGTH_W-1:0] tone_len   = TONE_LENGTH_RESET;

    // Ticks waiting to be offered, and the samples the generator owes us.
    in_item_t  tick_queue [$];
    out_item_t due_samples [$];
    out_item_t want;

    int mismatch_count = 0;
    int src_hold       = 0;
    int src_calm       = 0;
    int sink_hold      = 0;
    int sink_calm      = 0;
    int quiet_cycles   = 0;

    // The sine table is filled from the real-valued sine, using the quarter-wave
    // symmetry so that mirrored entries are exactly equal in magnitude. Values
    // are rounded to the nearest integer with halves away from zero; the
    // arguments here are never negative, so adding a half and flooring does it.
    // Phase steps are f * 2^PH_W / 8000, rounded to nearest with halves upwards.
    function automatic void build_model_tables();
        real amp;
        real s;
        int  quarter;
        int  quad;
        int  r;
        int  m;
        int  mag;
        quarter = LUT_SIZE / 4;
        amp     = real'((1 << (SAMP_W - 1)) - 1);
        for (int k = 0; k < LUT_SIZE; k++) begin
            quad        = k / quarter;
            r           = k % quarter;
            m           = (quad % 2 == 1) ? quarter - r : r;
            s           = $sin(TWO_PI * real'(m) / real'(LUT_SIZE));
            mag         = int'($floor(s * amp + 0.5));
            sine_lut[k] = (quad >= 2) ? -mag : mag;
        end
        for (int i = 0; i < 4; i++) begin
            row_step[i] = PH_W'(((64'(ROW_HZ[i]) << PH_W) + RATE_HZ / 2) / RATE_HZ);
            col_step[i] = PH_W'(((64'(COL_HZ[i]) << PH_W) + RATE_HZ / 2) / RATE_HZ);
        end
    endfunction

    // Position of a key on the keypad, or -1 when the code is not a key.
    function automatic int keypad_cell(logic [KEY_W-1:0] key);
        for (int i = 0; i < 16; i++) begin
            if (key == KEYPAD[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Advances the tone model by one tick and returns the sample it produces.
    function automatic out_item_t synth_sample(in_item_t tick);
        out_item_t           smp;
        int                  pos;
        int                  sum;
        int                  v;
        logic [LENGTH_W-1:0] eff_len;
        smp     = '0;
        // A programmed length of zero behaves as a length of one.
        eff_len = (tone_len == '0) ? LENGTH_W'(1) : tone_len;
        if (tick.start_tone) begin
            pos = keypad_cell(tick.key_code);
            if (pos < 0) begin
                // A start on a non-key code silences any running tone.
                tone_on = 1'b0;
            end else begin
                // Any start, even in the middle of a tone, begins afresh.
                row_sel    = 2'(pos >> 2);
                col_sel    = 2'(pos & 3);
                row_acc    = '0;
                col_acc    = '0;
                done_count = '0;
                tone_on    = 1'b1;
            end
        end
        if (!tone_on) begin
            return smp;
        end
        sum = sine_lut[row_acc[PH_W-1 -: ADDR_W]] + sine_lut[col_acc[PH_W-1 -: ADDR_W]];
        if (SAMP_W <= 16) begin
            v = (sum >>> 1) <<< (16 - SAMP_W);
        end else begin
            v = sum >>> (SAMP_W - 15);
        end
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        if (v < -OUT_MAX) begin
            v = -OUT_MAX;
        end
        row_acc    = row_acc + row_step[row_sel];
        col_acc    = col_acc + col_step[col_sel];
        done_count = done_count + 16'd1;
        smp.sample_value = v[OUT_W-1:0];
        smp.tone_active  = 1'b1;
        // Comparing with >= also ends a tone at once when the length has been
        // lowered below the count already reached.
        smp.last_sample  = (done_count >= eff_len);
        if (smp.last_sample) begin
            tone_on = 1'b0;
        end
        return smp;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // Idle spell lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Source side. At each rising edge a transfer that has just completed is
    // handed to the tone model, and the next tick is offered, possibly after
    // an idle gap. While a tick is offered and not yet taken it is held
    // unchanged. A calm spell now and then gives runs of back-to-back ticks.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due_samples.push_back(synth_sample(s_data));
            end
            if (!s_valid || s_ready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_valid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    s_data  <= tick_queue.pop_front();
                    s_valid <= 1'b1;
                    if (src_calm > 0) begin
                        src_calm--;
                    end else if ($urandom_range(0, 99) < 3) begin
                        src_calm = $urandom_range(20, 120);
                    end else begin
                        src_hold = idle_length();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side. Each completed result transfer is compared field by field
    // with the oldest sample still owed. Ready is withdrawn for random spells,
    // again with occasional calm stretches of uninterrupted readiness.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_samples.size() == 0) begin
                    report_mismatch($sformatf("result %h arrived with none expected", m_data));
                end else begin
                    want = due_samples.pop_front();
                    if (m_data.sample_value !== want.sample_value) begin
                        report_mismatch($sformatf("sample_value %0d, expected %0d",
                                                  m_data.sample_value, want.sample_value));
                    end
                    if (m_data.tone_active !== want.tone_active) begin
                        report_mismatch($sformatf("tone_active %b, expected %b",
                                                  m_data.tone_active, want.tone_active));
                    end
                    if (m_data.last_sample !== want.last_sample) begin
                        report_mismatch($sformatf("last_sample %b, expected %b",
                                                  m_data.last_sample, want.last_sample));
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (sink_calm > 0) begin
                    sink_calm--;
                end else if ($urandom_range(0, 99) < 3) begin
                    sink_calm = $urandom_range(20, 120);
                end else begin
                    sink_hold = idle_length();
                end
            end
        end
    end

    // The run is ended as hung once neither channel has moved a transfer for
    // too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** dtmf_tone_generator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic in_item_t make_tick(logic start, logic [KEY_W-1:0] key);
        in_item_t tick;
        tick.start_tone = start;
        tick.key_code   = key;
        return tick;
    endfunction

    // A plain tick carries a random key code, which the generator must ignore.
    task automatic push_plain(input int count);
        repeat (count) begin
            tick_queue.push_back(make_tick(1'b0, KEY_W'($urandom)));
        end
    endtask

    // A start on a random key followed by a number of plain ticks.
    task automatic push_tone(input int ticks);
        tick_queue.push_back(make_tick(1'b1, KEYPAD[$urandom_range(0, 15)]));
        push_plain(ticks);
    endtask

    function automatic logic [KEY_W-1:0] bad_key();
        logic [KEY_W-1:0] k;
        do begin
            k = KEY_W'($urandom_range(0, 255));
        end while (keypad_cell(k) >= 0);
        return k;
    endfunction

    // Waits until every tick has been taken and every owed sample has come
    // back, then lets the pipeline settle.
    task automatic settle();
        while (tick_queue.size() != 0 || s_valid || due_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // The length register is only written with the generator drained. The
    // tone state itself is kept, so a tone may well be half played here.
    task automatic write_tone_length(input logic [LENGTH_W-1:0] len);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        tone_len     = len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [LENGTH_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return LENGTH_W'($urandom_range(1, 12));
        end else if (r < 70) begin
            return LENGTH_W'($urandom_range(13, 60));
        end else if (r < 80) begin
            return LENGTH_W'($urandom_range(0, 1));
        end else if (r < 90) begin
            return ($urandom_range(0, 1) == 0) ? 16'hFFFF : LENGTH_W'($urandom_range(1000, 65535));
        end
        return LENGTH_W'($urandom_range(0, 65535));
    endfunction

    // Mostly whole key presses: a start and enough ticks to reach the last
    // sample, sometimes cut short by the next start, sometimes running on into
    // silence. The rest is non-key starts, bare ticks and lone starts.
    task automatic fill_random_phase(input int items);
        int made;
        int eff;
        int r;
        int ticks;
        made = 0;
        eff  = (tone_len == '0) ? 1 : int'(tone_len);
        while (made < items) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                if (eff > 150) begin
                    ticks = $urandom_range(0, 60);
                end else begin
                    case ($urandom_range(0, 3))
                        0, 1: ticks = eff - 1;
                        2: ticks = $urandom_range(0, eff - 1);
                        default: ticks = eff - 1 + $urandom_range(1, 4);
                    endcase
                end
                push_tone(ticks);
                made += ticks + 1;
            end else if (r < 85) begin
                tick_queue.push_back(make_tick(1'b1, bad_key()));
                made++;
            end else if (r < 95) begin
                ticks = $urandom_range(1, 5);
                push_plain(ticks);
                made += ticks;
            end else begin
                push_tone(0);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        build_model_tables();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, at the reset length. An idle tick with every key bit
        // set, then every key started in turn (each start abandons the tone
        // before it), then starts on the codes 0x00 and 0xFF, which are not
        // keys and must silence the generator.
        tick_queue.push_back(make_tick(1'b0, 8'hFF));
        for (int i = 0; i < 16; i++) begin
            tick_queue.push_back(make_tick(1'b1, KEYPAD[i]));
        end
        push_plain(1);
        tick_queue.push_back(make_tick(1'b1, 8'h00));
        push_plain(1);
        tick_queue.push_back(make_tick(1'b1, KEYPAD[5]));
        tick_queue.push_back(make_tick(1'b1, 8'hFF));

        // A length of zero behaves as one: every sample is the last.
        write_tone_length('0);
        tick_queue.push_back(make_tick(1'b1, KEY_HASH));
        push_plain(1);

        // Largest length.
        write_tone_length(16'hFFFF);
        tick_queue.push_back(make_tick(1'b1, KEY_D));
        push_plain(1);

        // Lowering the length below the samples already played: the very next
        // sample is the last, and the one after that is silence.
        write_tone_length(16'd6);
        tick_queue.push_back(make_tick(1'b1, KEY_0));
        push_plain(3);
        write_tone_length(16'd2);
        push_plain(2);

        write_tone_length(16'd1);
        tick_queue.push_back(make_tick(1'b1, KEY_STAR));
        push_plain(1);

        // Random part: a fresh tone length for every phase.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_tone_length(pick_length());
            fill_random_phase(ITEMS_PER_PHASE);
        end

        settle();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** dtmf_tone_generator: PASSED **");
        end else begin
            $display("** dtmf_tone_generator: FAILED **");
        end
        $finish;
    end

endmodule
